@@ design/mbpc_pkg.sv @@
// types and constants shared by the button press classifier
// no dependencies
package mbpc_pkg;

    localparam int unsigned MAX_BUTTONS = 5;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned MS_W        = 16;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_APP_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;

    localparam logic [1:0] MODE_NO_SUPPRESS     = 2'd0;
    localparam logic [1:0] MODE_SUPPRESS_B0     = 2'd1;
    localparam logic [1:0] MODE_SUPPRESS_B1     = 2'd2;
    localparam logic [1:0] MODE_NO_SUPPRESS_ALT = 2'd3;

    localparam logic [1:0]             RST_APP_MODE    = 2'd0;
    localparam logic [MAX_BUTTONS-1:0] RST_LONG_ENABLE = 5'd19;
    localparam logic [MS_W-1:0]        RST_LONG_PRESS  = 16'd4000;
    localparam logic [MS_W-1:0]        RST_WARNING     = 16'd2000;
    localparam logic [MS_W-1:0]        RST_DEBOUNCE    = 16'd50;

    typedef struct packed {
        logic [MAX_BUTTONS-1:0] levels;
        logic [TIME_W-1:0]      now_ms;
    } sample_t;

    typedef struct packed {
        logic [MAX_BUTTONS-1:0] click_mask;
        logic [MAX_BUTTONS-1:0] warning_mask;
        logic [MAX_BUTTONS-1:0] long_press_mask;
        logic [MAX_BUTTONS-1:0] held_mask;
    } result_t;

    typedef struct packed {
        logic [1:0]             op_mode;
        logic [MAX_BUTTONS-1:0] long_enable_mask;
        logic [MS_W-1:0]        long_limit;
        logic [MS_W-1:0]        warn_limit;
        logic [MS_W-1:0]        click_min;
    } cfg_t;

    typedef struct packed {
        logic              pressed;
        logic              long_done;
        logic              warn_done;
        logic [TIME_W-1:0] press_start;
    } btn_state_t;

    typedef struct packed {
        logic click;
        logic warn;
        logic long_press;
        logic held;
    } btn_flags_t;

endpackage

@@ design/multi_button_press_classifier_top.sv @@
// Button press classifier: each sample word walks the buttons one per cycle, unless
// a stalled result holds it, through a state memory (read, update, write back); its
// result word enters the output register as its last button leaves the update stage,
// and the next sample starts right behind it. Buttons above five never press. The
// configuration port is always ready; the user writes it while idle (not enforced).
module multi_button_press_classifier_top #(
    parameter int unsigned NUM_BUTTONS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  mbpc_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output mbpc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbpc_pkg::MS_W-1:0]         cfg_data
);
    import mbpc_pkg::*;

    localparam int unsigned NB_EFF   = (NUM_BUTTONS > MAX_BUTTONS) ? MAX_BUTTONS : NUM_BUTTONS;
    localparam int unsigned IDX_W    = (NB_EFF > 1) ? $clog2(NB_EFF) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NB_EFF - 1);
    localparam logic [MAX_BUTTONS-1:0] BTN_MASK = MAX_BUTTONS'((64'd1 << NB_EFF) - 64'd1);

    cfg_t cfg_reg;

    logic             it_valid_reg;
    sample_t          it_reg;
    logic [IDX_W-1:0] cnt_reg;

    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic              m_level_reg;
    logic [TIME_W-1:0] m_now_reg;
    logic              m_last_reg;
    logic              m_first_reg;

    logic       fwd_hit_reg;
    btn_state_t fwd_data_reg;

    result_t acc_reg;
    result_t result_reg;
    logic    result_valid_reg;

    logic       advance;
    logic       issue;
    logic       last_issue;
    logic       accept;
    btn_state_t rd_data;
    btn_state_t cur_state;
    btn_state_t upd_state;
    btn_flags_t flags;
    logic [MAX_BUTTONS-1:0] onehot;
    result_t    bits;
    result_t    res_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode          <= RST_APP_MODE;
            cfg_reg.long_enable_mask <= RST_LONG_ENABLE;
            cfg_reg.long_limit       <= RST_LONG_PRESS;
            cfg_reg.warn_limit       <= RST_WARNING;
            cfg_reg.click_min        <= RST_DEBOUNCE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_APP_MODE:    cfg_reg.op_mode          <= cfg_data[1:0];
                REG_LONG_ENABLE: cfg_reg.long_enable_mask <= cfg_data[MAX_BUTTONS-1:0];
                REG_LONG_PRESS:  cfg_reg.long_limit       <= cfg_data;
                REG_WARNING:     cfg_reg.warn_limit       <= cfg_data;
                REG_DEBOUNCE:    cfg_reg.click_min        <= cfg_data;
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // sequencing
    assign advance      = !(m_valid_reg && m_last_reg && result_valid_reg && result_stall);
    assign issue        = it_valid_reg && advance;
    assign last_issue   = (cnt_reg == LAST_IDX);
    assign sample_stall = it_valid_reg && !(issue && last_issue);
    assign accept       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (accept)
        begin
            it_valid_reg <= 1'b1;
            cnt_reg      <= '0;
        end
        else if (issue && last_issue)
        begin
            it_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_reg <= sample;
        end
    end

    // update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= issue;
            fwd_hit_reg <= issue && m_valid_reg && (m_idx_reg == cnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_idx_reg    <= cnt_reg;
            m_level_reg  <= it_reg.levels[cnt_reg];
            m_now_reg    <= it_reg.now_ms;
            m_last_reg   <= last_issue;
            m_first_reg  <= (cnt_reg == IDX_W'(0));
            fwd_data_reg <= upd_state;
        end
    end

    mbpc_state_mem #(
        .DEPTH (NB_EFF),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (issue),
        .rd_idx  (cnt_reg),
        .rd_data (rd_data),
        .wr_en   (m_valid_reg && advance),
        .wr_idx  (m_idx_reg),
        .wr_data (upd_state)
    );

    assign cur_state = fwd_hit_reg ? fwd_data_reg : rd_data;

    mbpc_classify #(
        .IDX_W (IDX_W)
    ) u_classify (
        .cur    (cur_state),
        .level  (m_level_reg),
        .now_ms (m_now_reg),
        .idx    (m_idx_reg),
        .cfg    (cfg_reg),
        .nxt    (upd_state),
        .flags  (flags)
    );

    // result assembly
    assign onehot = MAX_BUTTONS'(1) << m_idx_reg;

    always_comb
    begin
        bits.click_mask      = flags.click      ? onehot : '0;
        bits.warning_mask    = flags.warn       ? onehot : '0;
        bits.long_press_mask = flags.long_press ? onehot : '0;
        bits.held_mask       = flags.held       ? onehot : '0;
        res_next             = m_first_reg ? bits : (acc_reg | bits);
    end

    always_ff @(posedge clk)
    begin
        if (advance && m_valid_reg)
        begin
            acc_reg <= res_next;
        end
        if (advance && m_valid_reg && m_last_reg)
        begin
            result_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && m_valid_reg && m_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_accept_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (it_valid_reg && (cnt_reg == '0)))
        else $error("accepted word does not start at button zero");

    a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !advance) |=> (m_valid_reg && $stable(m_idx_reg)))
        else $error("update stage moved while frozen");

    a_fwd_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> m_valid_reg)
        else $error("forwarded state without an update in flight");

    a_click_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (((result.click_mask & result.held_mask) == '0) &&
                          ((result.held_mask & ~BTN_MASK) == '0)))
        else $error("click on a held or absent button");

endmodule

@@ design/mbpc_state_mem.sv @@
// per-button state memory, registered read, valid bit per entry
// depends on mbpc_pkg
module mbpc_state_mem #(
    parameter int unsigned DEPTH = 5,
    parameter int unsigned IDX_W = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output mbpc_pkg::btn_state_t rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  mbpc_pkg::btn_state_t wr_data
);
    import mbpc_pkg::*;

    btn_state_t mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    btn_state_t rd_raw_reg;
    logic rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

@@ design/mbpc_classify.sv @@
// next-state and event logic for one button on one sample
// depends on mbpc_pkg
module mbpc_classify #(
    parameter int unsigned IDX_W = 3
) (
    input  mbpc_pkg::btn_state_t cur,
    input  logic                 level,
    input  logic [31:0]          now_ms,
    input  logic [IDX_W-1:0]     idx,
    input  mbpc_pkg::cfg_t       cfg,
    output mbpc_pkg::btn_state_t nxt,
    output mbpc_pkg::btn_flags_t flags
);
    import mbpc_pkg::*;

    logic [TIME_W-1:0] held_ms;
    logic suppressed;
    logic enabled;
    logic over_warn;
    logic under_long;
    logic over_long;
    logic over_debounce;

    assign held_ms       = now_ms - cur.press_start;
    assign suppressed    = ((idx == IDX_W'(0)) && (cfg.op_mode == MODE_SUPPRESS_B0)) ||
                           ((idx == IDX_W'(1)) && (cfg.op_mode == MODE_SUPPRESS_B1));
    assign enabled       = cfg.long_enable_mask[idx] && !suppressed;
    assign over_warn     = held_ms > TIME_W'(cfg.warn_limit);
    assign under_long    = held_ms < TIME_W'(cfg.long_limit);
    assign over_long     = held_ms > TIME_W'(cfg.long_limit);
    assign over_debounce = held_ms > TIME_W'(cfg.click_min);

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        if (level)
        begin
            if (!cur.pressed)
            begin
                nxt.pressed     = 1'b1;
                nxt.press_start = now_ms;
                nxt.long_done   = 1'b0;
                nxt.warn_done   = 1'b0;
            end
            else if (enabled)
            begin
                if (!cur.warn_done && over_warn && under_long)
                begin
                    flags.warn    = 1'b1;
                    nxt.warn_done = 1'b1;
                end
                if (!cur.long_done && over_long)
                begin
                    flags.long_press = 1'b1;
                    nxt.long_done    = 1'b1;
                end
            end
        end
        else if (cur.pressed)
        begin
            nxt.pressed = 1'b0;
            flags.click = !cur.long_done && over_debounce;
        end
        flags.held = nxt.pressed;
    end

endmodule
